// ===== src/keyed_latency_stats_table_assert.svh =====
// Assertion macros used by the keyed latency stats table RTL.
`ifndef KEYED_LATENCY_STATS_TABLE_ASSERT_SVH
`define KEYED_LATENCY_STATS_TABLE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define KLS_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error(msg);
// Condition that must hold on every rising clock edge outside reset.
`define KLS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

// ===== src/klst_pkg.sv =====
// Package with types and constants of the keyed latency stats table.
package klst_pkg;
	localparam int unsigned TableDepth = 4096;
	localparam int unsigned IdxW = $clog2(TableDepth);
	localparam int unsigned CntW = IdxW + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_UPD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] calls;
		logic [63:0] sum;
		logic [63:0] peak;
	} id_ent_t;

	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] calls;
		logic [63:0] sum;
	} nm_ent_t;
endpackage

// ===== src/klst_id_mem.sv =====
// Id table storage: one synchronous memory of id entries.
module klst_id_mem (
	input  logic                      clk,
	input  logic [klst_pkg::IdxW-1:0] raddr,
	output klst_pkg::id_ent_t         rdata,
	input  logic                      we,
	input  logic [klst_pkg::IdxW-1:0] waddr,
	input  klst_pkg::id_ent_t         wdata
);
	import klst_pkg::*;
	id_ent_t mem [TableDepth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/klst_nm_mem.sv =====
// Name table storage: one synchronous memory of name entries.
module klst_nm_mem (
	input  logic                      clk,
	input  logic [klst_pkg::IdxW-1:0] raddr,
	output klst_pkg::nm_ent_t         rdata,
	input  logic                      we,
	input  logic [klst_pkg::IdxW-1:0] waddr,
	input  klst_pkg::nm_ent_t         wdata
);
	import klst_pkg::*;
	nm_ent_t mem [TableDepth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/keyed_latency_stats_table.sv =====
// Keyed latency stats table: per-id and per-name latency counters.
// Input channel (valid/stall): kind 0 is a latency event, kind 1 reads both
// tables at slot. Each beat yields exactly one result beat on the output
// channel (out_valid/out_stall).
// An event scans the used slots of both tables in parallel, one slot per
// cycle through the registered memory read port, stopping when both keys are
// found or the used range is exhausted. A missing key is appended at the end
// of its table unless the table is full (then that half reports zeros).
// After its scan, an event passes the wait, update and output states before
// its result is valid; a read item goes from accept through the wait and
// output states only.
// One item is in flight at a time; the scan loop over the memory sets the rate.
// The next item is taken while the previous result still waits in the
// output register, but the update of that item is already committed.
// Reset clears the used counts and the global totals; table memories are not
// cleared, since slots beyond the used count are never read.
// While the receiver stalls, the result is held stable in the output register
// and a further finished result waits in the block until the register frees.
module keyed_latency_stats_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] tgid,
	input  logic [63:0] comm_low,
	input  logic [63:0] comm_high,
	input  logic [63:0] event_ns,
	input  logic [11:0] slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pid_ok,
	output logic [31:0] tgid_out,
	output logic [63:0] pid_calls,
	output logic [63:0] pid_total_ns,
	output logic [63:0] pid_max_ns,
	output logic        comm_ok,
	output logic [63:0] name_low_out,
	output logic [63:0] name_high_out,
	output logic [63:0] comm_calls,
	output logic [63:0] comm_total_ns,
	output logic [63:0] total_calls,
	output logic [63:0] global_latency_ns
);
	import klst_pkg::*;
	`include "keyed_latency_stats_table_assert.svh"

	state_t state_q, state_nx;

	// Item registers.
	logic            kind_q;
	logic [31:0]     key_q;
	logic [63:0]     lo_q, hi_q, lat_q;
	logic [IdxW-1:0] slot_q;

	logic [CntW-1:0] id_used_q, nm_used_q;
	logic [63:0]     all_calls_q, all_lat_q;

	// Scan bookkeeping.
	logic [CntW-1:0] ptr_q;      // address issued this cycle
	logic            rd_vld_s1;  // a read returns this cycle
	logic [CntW-1:0] rd_addr_s1;
	logic            id_hit_q, nm_hit_q;
	logic [IdxW-1:0] id_idx_q, nm_idx_q;
	id_ent_t         id_ent_hold;
	nm_ent_t         nm_ent_hold;

	logic [IdxW-1:0] raddr;
	id_ent_t         id_rd, id_wd;
	nm_ent_t         nm_rd, nm_wd;
	logic            id_we, nm_we;

	// Result register.
	logic            out_vld_q;
	logic            res_ok_p, res_ok_c;
	id_ent_t         res_id;
	nm_ent_t         res_nm;

	logic in_acc, out_free;
	logic id_match, nm_match, id_done, nm_done, scan_end;
	logic id_full, nm_full;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_vld_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	assign id_match = rd_vld_s1 && (rd_addr_s1 < id_used_q) && (id_rd.key == key_q);
	assign nm_match = rd_vld_s1 && (rd_addr_s1 < nm_used_q) &&
		(nm_rd.lo == lo_q) && (nm_rd.hi == hi_q);
	assign id_done  = id_hit_q || id_match;
	assign nm_done  = nm_hit_q || nm_match;
	// Scan ends when both keys are found or the last issued read covered
	// every used slot.
	assign scan_end = (id_done && nm_done) ||
		(rd_vld_s1 && rd_addr_s1 + 1'b1 >= id_used_q && rd_addr_s1 + 1'b1 >= nm_used_q) ||
		(id_used_q == '0 && nm_used_q == '0);
	assign id_full  = (id_used_q == CntW'(TableDepth));
	assign nm_full  = (nm_used_q == CntW'(TableDepth));

	assign raddr = (state_q == ST_IDLE) ? slot : ptr_q[IdxW-1:0];

	klst_id_mem u_id_mem (
		.clk(clk), .raddr(raddr), .rdata(id_rd),
		.we(id_we), .waddr(id_idx_q), .wdata(id_wd)
	);
	klst_nm_mem u_nm_mem (
		.clk(clk), .raddr(raddr), .rdata(nm_rd),
		.we(nm_we), .waddr(nm_idx_q), .wdata(nm_wd)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_nx = kind ? ST_WAIT : ST_SCAN;
			ST_SCAN: if (scan_end) state_nx = ST_WAIT;
			ST_WAIT: state_nx = kind_q ? ST_OUT : ST_UPD;
			ST_UPD:  state_nx = ST_OUT;
			ST_OUT:  if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Updated entries (hit entry or new entry registered at ST_WAIT into res_*).
	// Drop the write of a table that had no room for a missing key.
	always_comb begin
		id_wd       = res_id;
		id_wd.calls = res_id.calls + 64'd1;
		id_wd.sum   = res_id.sum + lat_q;
		id_wd.peak  = (lat_q > res_id.peak) ? lat_q : res_id.peak;
		nm_wd       = res_nm;
		nm_wd.calls = res_nm.calls + 64'd1;
		nm_wd.sum   = res_nm.sum + lat_q;
		id_we       = (state_q == ST_UPD) && res_ok_p;
		nm_we       = (state_q == ST_UPD) && res_ok_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			id_used_q   <= '0;
			nm_used_q   <= '0;
			all_calls_q <= '0;
			all_lat_q   <= '0;
			out_vld_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			id_hit_q    <= 1'b0;
			nm_hit_q    <= 1'b0;
		end else begin
			state_q   <= state_nx;
			// Raise valid when a result loads, hold it while the receiver stalls.
			out_vld_q <= (state_q == ST_OUT && out_free) || (out_vld_q && out_stall);
			rd_vld_s1 <= (state_q == ST_SCAN) && !scan_end;
			unique case (state_q)
				ST_IDLE: begin
					id_hit_q <= 1'b0;
					nm_hit_q <= 1'b0;
				end
				ST_SCAN: begin
					if (id_match && !id_hit_q) id_hit_q <= 1'b1;
					if (nm_match && !nm_hit_q) nm_hit_q <= 1'b1;
				end
				ST_WAIT: begin
					// Append missing keys where there is room.
					if (!kind_q) begin
						if (!id_hit_q && !id_full) id_used_q <= id_used_q + 1'b1;
						if (!nm_hit_q && !nm_full) nm_used_q <= nm_used_q + 1'b1;
						all_calls_q <= all_calls_q + 64'd1;
						all_lat_q   <= all_lat_q + lat_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= ptr_q;
		if (in_acc) begin
			kind_q <= kind;
			key_q  <= tgid;
			lo_q   <= comm_low;
			hi_q   <= comm_high;
			lat_q  <= event_ns;
			slot_q <= slot;
			ptr_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (state_q == ST_SCAN) begin
			if (id_match && !id_hit_q) id_idx_q <= rd_addr_s1[IdxW-1:0];
			if (nm_match && !nm_hit_q) nm_idx_q <= rd_addr_s1[IdxW-1:0];
		end
		if (state_q == ST_WAIT) begin
			if (kind_q) begin
				// Read item: memory data for slot_q arrives now.
				res_ok_p <= {1'b0, slot_q} < id_used_q;
				res_ok_c <= {1'b0, slot_q} < nm_used_q;
				res_id   <= id_rd;
				res_nm   <= nm_rd;
			end else begin
				res_ok_p <= id_hit_q || !id_full;
				res_ok_c <= nm_hit_q || !nm_full;
				if (!id_hit_q) begin
					id_idx_q <= id_used_q[IdxW-1:0];
					res_id   <= '{key: key_q, calls: 64'd0, sum: 64'd0, peak: 64'd0};
				end else begin
					res_id <= id_ent_hold;
				end
				if (!nm_hit_q) begin
					nm_idx_q <= nm_used_q[IdxW-1:0];
					res_nm   <= '{lo: lo_q, hi: hi_q, calls: 64'd0, sum: 64'd0};
				end else begin
					res_nm <= nm_ent_hold;
				end
			end
		end
		if (state_q == ST_UPD) begin
			res_id <= id_wd;
			res_nm <= nm_wd;
		end
		// Capture hit entries as they stream past.
		if (state_q == ST_SCAN && id_match && !id_hit_q) id_ent_hold <= id_rd;
		if (state_q == ST_SCAN && nm_match && !nm_hit_q) nm_ent_hold <= nm_rd;
		if (state_q == ST_OUT && out_free) begin
			pid_ok            <= res_ok_p;
			tgid_out          <= res_ok_p ? res_id.key : 32'd0;
			pid_calls         <= res_ok_p ? res_id.calls : 64'd0;
			pid_total_ns      <= res_ok_p ? res_id.sum : 64'd0;
			pid_max_ns        <= res_ok_p ? res_id.peak : 64'd0;
			comm_ok           <= res_ok_c;
			name_low_out      <= res_ok_c ? res_nm.lo : 64'd0;
			name_high_out     <= res_ok_c ? res_nm.hi : 64'd0;
			comm_calls        <= res_ok_c ? res_nm.calls : 64'd0;
			comm_total_ns     <= res_ok_c ? res_nm.sum : 64'd0;
			total_calls       <= all_calls_q;
			global_latency_ns <= all_lat_q;
		end
	end

	assign out_valid = out_vld_q;

	`KLS_ASSERT_ALWAYS(a_used_bound, clk, arst_n,
		id_used_q <= CntW'(TableDepth) && nm_used_q <= CntW'(TableDepth),
		"used count beyond table depth")
	`KLS_ASSERT_IMP(a_we_event, clk, arst_n, id_we || nm_we, !kind_q, "table write on read item")
	`KLS_ASSERT_IMP(a_out_hold, clk, arst_n, out_vld_q && out_stall,
		##1 out_vld_q, "stalled result dropped")
endmodule

// ===== tb/tb_keyed_latency_stats_table.sv =====
// Testbench for the keyed latency stats table: event and read beats checked against a predictor.
`timescale 1ns / 100ps

module tb_keyed_latency_stats_table;
	import klst_pkg::*;

	localparam int unsigned KIND_EVENT = 0;
	localparam int unsigned KIND_READ  = 1;
	localparam longint unsigned CYCLE_LIMIT = 64'd3000000;

	typedef struct packed {
		logic        pid_ok;
		logic [31:0] tgid;
		logic [63:0] pid_calls;
		logic [63:0] pid_total;
		logic [63:0] pid_max;
		logic        comm_ok;
		logic [63:0] name_lo;
		logic [63:0] name_hi;
		logic [63:0] comm_calls;
		logic [63:0] comm_total;
		logic [63:0] all_calls;
		logic [63:0] all_lat;
	} stats_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [31:0] tgid;
	logic [63:0] comm_low;
	logic [63:0] comm_high;
	logic [63:0] event_ns;
	logic [11:0] slot;
	logic        out_valid;
	logic        out_stall;
	logic        pid_ok;
	logic [31:0] tgid_out;
	logic [63:0] pid_calls;
	logic [63:0] pid_total_ns;
	logic [63:0] pid_max_ns;
	logic        comm_ok;
	logic [63:0] name_low_out;
	logic [63:0] name_high_out;
	logic [63:0] comm_calls;
	logic [63:0] comm_total_ns;
	logic [63:0] total_calls;
	logic [63:0] global_latency_ns;

	// Shadow copy of both tables and the global totals.
	id_ent_t        pid_tab[$];
	nm_ent_t        name_tab[$];
	logic [63:0]    sum_calls;
	logic [63:0]    sum_lat;
	stats_t         pending_stats[$];
	int unsigned    mismatches;
	longint unsigned cycles;
	// Ids and names already used, so random traffic keeps hitting known entries.
	logic [31:0]    seen_ids[$];
	logic [127:0]   seen_names[$];

	keyed_latency_stats_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .tgid(tgid), .comm_low(comm_low), .comm_high(comm_high),
		.event_ns(event_ns), .slot(slot),
		.out_valid(out_valid), .out_stall(out_stall),
		.pid_ok(pid_ok), .tgid_out(tgid_out), .pid_calls(pid_calls),
		.pid_total_ns(pid_total_ns), .pid_max_ns(pid_max_ns),
		.comm_ok(comm_ok), .name_low_out(name_low_out), .name_high_out(name_high_out),
		.comm_calls(comm_calls), .comm_total_ns(comm_total_ns),
		.total_calls(total_calls), .global_latency_ns(global_latency_ns)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run watchdog: fail if the traffic never drains.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Compute the expected result of one beat and advance the shadow tables.
	function automatic stats_t predict_stats(logic k, logic [31:0] id, logic [63:0] lo,
			logic [63:0] hi, logic [63:0] lat, logic [11:0] s);
		stats_t r;
		int     pi;
		int     ci;
		r  = '0;
		pi = -1;
		ci = -1;
		if (k == 1'b1) begin
			if (s < pid_tab.size()) pi = int'(s);
			if (s < name_tab.size()) ci = int'(s);
		end else begin
			foreach (pid_tab[i]) if (pi < 0 && pid_tab[i].key == id) pi = i;
			if (pi < 0 && pid_tab.size() < TableDepth) begin
				pid_tab.push_back('{key: id, calls: '0, sum: '0, peak: '0});
				pi = int'(pid_tab.size()) - 1;
			end
			foreach (name_tab[i])
				if (ci < 0 && name_tab[i].lo == lo && name_tab[i].hi == hi) ci = i;
			if (ci < 0 && name_tab.size() < TableDepth) begin
				name_tab.push_back('{lo: lo, hi: hi, calls: '0, sum: '0});
				ci = int'(name_tab.size()) - 1;
			end
			if (pi >= 0) begin
				pid_tab[pi].calls += 64'd1;
				pid_tab[pi].sum   += lat;
				if (lat > pid_tab[pi].peak) pid_tab[pi].peak = lat;
			end
			if (ci >= 0) begin
				name_tab[ci].calls += 64'd1;
				name_tab[ci].sum   += lat;
			end
			sum_calls += 64'd1;
			sum_lat   += lat;
		end
		if (pi >= 0) begin
			r.pid_ok    = 1'b1;
			r.tgid      = pid_tab[pi].key;
			r.pid_calls = pid_tab[pi].calls;
			r.pid_total = pid_tab[pi].sum;
			r.pid_max   = pid_tab[pi].peak;
		end
		if (ci >= 0) begin
			r.comm_ok    = 1'b1;
			r.name_lo    = name_tab[ci].lo;
			r.name_hi    = name_tab[ci].hi;
			r.comm_calls = name_tab[ci].calls;
			r.comm_total = name_tab[ci].sum;
		end
		r.all_calls = sum_calls;
		r.all_lat   = sum_lat;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Sender: hold the beat until accepted, then drop valid for a gap or go on in the burst.
	int unsigned burst_left;

	task automatic send_beat(logic k, logic [31:0] id, logic [63:0] lo, logic [63:0] hi,
			logic [63:0] lat, logic [11:0] s);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		kind       <= k;
		tgid       <= id;
		comm_low   <= lo;
		comm_high  <= hi;
		event_ns   <= lat;
		slot       <= s;
		in_valid   <= 1'b1;
		pending_stats.push_back(predict_stats(k, id, lo, hi, lat, s));
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_event(logic [31:0] id, logic [127:0] name, logic [63:0] lat);
		send_beat(KIND_EVENT[0], id, name[63:0], name[127:64], lat, 12'($urandom));
	endtask

	task automatic send_read(logic [11:0] s);
		send_beat(KIND_READ[0], 32'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, s);
	endtask

	// Receiver stall pattern: random runs, each either quiet or stall-heavy.
	initial begin
		int unsigned mode_left;
		int unsigned heavy;
		out_stall = 1'b1;
		mode_left = 0;
		heavy = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 200);
				heavy = $urandom_range(0, 2);
			end
			mode_left--;
			if (!arst_n) out_stall <= 1'b1;
			else if (heavy == 0) out_stall <= 1'b0;
			else out_stall <= ($urandom_range(0, 3) < heavy);
		end
	end

	// Compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		stats_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_stats.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				mismatches++;
			end else begin
				want = pending_stats.pop_front();
				if (pid_ok !== want.pid_ok)
					report_mismatch("pid_ok", 64'(pid_ok), 64'(want.pid_ok));
				if (tgid_out !== want.tgid)
					report_mismatch("tgid_out", 64'(tgid_out), 64'(want.tgid));
				if (pid_calls !== want.pid_calls)
					report_mismatch("pid_calls", pid_calls, want.pid_calls);
				if (pid_total_ns !== want.pid_total)
					report_mismatch("pid_total_ns", pid_total_ns, want.pid_total);
				if (pid_max_ns !== want.pid_max)
					report_mismatch("pid_max_ns", pid_max_ns, want.pid_max);
				if (comm_ok !== want.comm_ok)
					report_mismatch("comm_ok", 64'(comm_ok), 64'(want.comm_ok));
				if (name_low_out !== want.name_lo)
					report_mismatch("name_low_out", name_low_out, want.name_lo);
				if (name_high_out !== want.name_hi)
					report_mismatch("name_high_out", name_high_out, want.name_hi);
				if (comm_calls !== want.comm_calls)
					report_mismatch("comm_calls", comm_calls, want.comm_calls);
				if (comm_total_ns !== want.comm_total)
					report_mismatch("comm_total_ns", comm_total_ns, want.comm_total);
				if (total_calls !== want.all_calls)
					report_mismatch("total_calls", total_calls, want.all_calls);
				if (global_latency_ns !== want.all_lat)
					report_mismatch("global_latency_ns", global_latency_ns, want.all_lat);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Reads before any event: every slot unused.
	task automatic test_empty_reads();
		send_read(12'd0);
		send_read(12'hFFF);
	endtask

	// Field extremes, wrap of sums, repeat hits, names differing only past a zero byte.
	task automatic test_directed();
		send_event(32'd0, 128'd0, 64'd0);
		send_event(32'hFFFF_FFFF, {128{1'b1}}, 64'hFFFF_FFFF_FFFF_FFFF);
		send_event(32'hFFFF_FFFF, {128{1'b1}}, 64'hFFFF_FFFF_FFFF_FFFF);
		send_event(32'hFFFF_FFFF, {128{1'b1}}, 64'd5);
		send_event(32'd0, 128'd0, 64'd3);
		send_event(32'd7, {64'h0, 64'h0000_0000_0041_0042}, 64'd10);
		send_event(32'd7, {64'h0, 64'h0000_0000_4100_0042}, 64'd9);
		send_event(32'd8, {64'h0100_0000_0000_0000, 64'h0000_0000_0041_0042}, 64'd11);
		send_event(32'h8000_0000, {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}, 64'd1);
		send_event(32'h5555_5555, {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
			64'h8000_0000_0000_0000);
		send_event(32'hAAAA_AAAA, 128'd0, 64'h8000_0000_0000_0000);
		for (int s = 0; s < 8; s++) send_read(12'(s));
		send_read(12'hFFF);
		send_read(12'h800);
	endtask

	// Mostly repeats of known keys with random latency; some fresh keys and reads.
	task automatic test_random_traffic(int unsigned n);
		logic [31:0]  id;
		logic [127:0] name;
		int unsigned  pick;
		for (int unsigned i = 0; i < n; i++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				send_read(12'($urandom_range(0, 24)));
			end else if (pick == 1) begin
				send_read(12'($urandom));
			end else begin
				if (seen_ids.size() == 0 || $urandom_range(0, 3) == 0) begin
					id = $urandom;
					seen_ids.push_back(id);
				end else id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
				if (seen_names.size() == 0 || $urandom_range(0, 3) == 0) begin
					name = {rand64(), rand64()};
					seen_names.push_back(name);
				end else name = seen_names[$urandom_range(0, seen_names.size() - 1)];
				send_event(id, name, $urandom_range(0, 7) == 0 ? ~64'($urandom) : rand64());
			end
		end
	endtask

	initial begin
		int unsigned drain;
		in_valid   = 1'b0;
		kind       = 1'b0;
		tgid       = '0;
		comm_low   = '0;
		comm_high  = '0;
		event_ns   = '0;
		slot       = '0;
		arst_n     = 1'b0;
		sum_calls  = '0;
		sum_lat    = '0;
		mismatches = 0;
		burst_left = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_reads();
		test_directed();
		test_random_traffic(120);

		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(negedge clk);
		// Hold a little longer to catch any stray result beat.
		drain = 0;
		while (drain < 200) begin
			@(negedge clk);
			drain++;
		end
		if (mismatches == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/klst_pkg.sv
src/klst_id_mem.sv
src/klst_nm_mem.sv
src/keyed_latency_stats_table.sv
tb/tb_keyed_latency_stats_table.sv
